// ===== hdl/ppw_pkg.sv =====
// Shared constants and types for the pivot partition worker store.
// Every module of the block imports this package. It has no dependencies.
package ppw_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int DRAW_W      = 16;
  localparam int MOD_IT_W    = $clog2(DRAW_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    OP_LOAD         = 3'd0,
    OP_PICK         = 3'd1,
    OP_COUNT        = 3'd2,
    OP_DROP_SMALLER = 3'd3,
    OP_DROP_LARGER  = 3'd4
  } func_e;

  typedef struct packed {
    func_e                     op;
    logic signed [WORD_W-1:0]  operand;
    logic        [DRAW_W-1:0]  draw;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             idle;
  } stat_t;

endpackage

// ===== hdl/ppw_front.sv =====
// Front end: accepts input beats, decodes the operation and queues commands.
// Depends on ppw_pkg. Unknown operation codes are accepted and discarded here.
module ppw_front import ppw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [WORD_W-1:0] operand_i,
  input  logic [DRAW_W-1:0]        random_draw_i,
  output logic                     cmd_valid_o,
  input  logic                     cmd_ready_i,
  output cmd_t                     cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              known;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  always_comb begin
    new_cmd.operand = operand_i;
    new_cmd.draw    = random_draw_i;
    new_cmd.op      = OP_LOAD;
    known           = 1'b1;
    unique case (func_i)
      OP_LOAD:         new_cmd.op = OP_LOAD;
      OP_PICK:         new_cmd.op = OP_PICK;
      OP_COUNT:        new_cmd.op = OP_COUNT;
      OP_DROP_SMALLER: new_cmd.op = OP_DROP_SMALLER;
      OP_DROP_LARGER:  new_cmd.op = OP_DROP_LARGER;
      default:         known = 1'b0;
    endcase
  end

  assign in_ready_o  = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i & in_ready_o & known;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== hdl/ppw_mod.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on ppw_pkg. The remainder is held until the next start.
module ppw_mod import ppw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DRAW_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [CNT_W-1:0]  rem_o
);

  logic                busy_q;
  logic                done_q;
  logic [MOD_IT_W-1:0] it_q;
  logic [DRAW_W-1:0]   shift_q;
  logic [CNT_W-1:0]    div_q;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [CNT_W:0]      trial;

  always_comb begin
    trial = {rem_q, shift_q[DRAW_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = CNT_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      it_q    <= '0;
      shift_q <= '0;
      div_q   <= '0;
      rem_q   <= '0;
    end else begin
      done_q <= !start_i && busy_q && (it_q == MOD_IT_W'(DRAW_W - 1));
      if (start_i) begin
        busy_q  <= 1'b1;
        it_q    <= '0;
        shift_q <= dividend_i;
        div_q   <= divisor_i;
        rem_q   <= '0;
      end else if (busy_q) begin
        rem_q   <= rem_d;
        shift_q <= {shift_q[DRAW_W-2:0], 1'b0};
        it_q    <= it_q + 1'b1;
        if (it_q == MOD_IT_W'(DRAW_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hdl/ppw_back.sv =====
// Back end: element store, sweep sequencer for count and compaction, and the
// reply register. Depends on ppw_pkg and instantiates ppw_mod for picks.
module ppw_back import ppw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  cmd_t                     cmd_i,
  output logic                     reply_valid_o,
  input  logic                     reply_ready_i,
  output logic signed [WORD_W-1:0] reply_value_o,
  output logic                     reply_kind_o,
  output stat_t                    stat_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PICK_RD,
    ST_SCAN,
    ST_REPLY
  } st_e;

  st_e                      state_q;
  func_e                    op_q;
  logic [CNT_W-1:0]         count_q;
  logic signed [WORD_W-1:0] pivot_q;
  logic [CNT_W-1:0]         rd_idx_q;
  logic [CNT_W-1:0]         acc_q;
  logic                     chk_q;
  logic signed [WORD_W-1:0] res_value_q;
  logic                     res_kind_q;
  logic                     reply_valid_q;
  logic signed [WORD_W-1:0] reply_value_q;
  logic                     reply_kind_q;

  logic signed [WORD_W-1:0] mem_q [STORE_DEPTH];
  logic signed [WORD_W-1:0] rdata_q;

  logic                     take;
  logic                     mod_start;
  logic                     mod_done;
  logic [CNT_W-1:0]         mod_rem;
  logic                     hit;
  logic                     issue;
  logic                     scan_done;
  logic                     out_free;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [IDX_W-1:0]         raddr;
  logic signed [WORD_W-1:0] wdata;

  ppw_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (cmd_i.draw),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    cmd_ready_o = (state_q == ST_IDLE);
    take        = cmd_valid_i & cmd_ready_o;
    mod_start   = take && (cmd_i.op == OP_PICK) && (count_q != '0);
    out_free    = !reply_valid_q || reply_ready_i;
    issue       = (state_q == ST_SCAN) && (rd_idx_q < count_q);
    scan_done   = (state_q == ST_SCAN) && !issue && !chk_q;
    raddr       = (state_q == ST_SCAN) ? rd_idx_q[IDX_W-1:0] : mod_rem[IDX_W-1:0];

    unique case (op_q)
      OP_COUNT:        hit = (rdata_q > pivot_q);
      OP_DROP_SMALLER: hit = !(rdata_q < pivot_q);
      OP_DROP_LARGER:  hit = !(rdata_q > pivot_q);
      default:         hit = 1'b0;
    endcase

    we    = 1'b0;
    waddr = count_q[IDX_W-1:0];
    wdata = cmd_i.operand;
    if (take && (cmd_i.op == OP_LOAD) && (count_q < CNT_W'(STORE_DEPTH))) begin
      we = 1'b1;
    end else if ((state_q == ST_SCAN) && chk_q && hit && (op_q != OP_COUNT)) begin
      we    = 1'b1;
      waddr = acc_q[IDX_W-1:0];
      wdata = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_LOAD;
      count_q       <= '0;
      pivot_q       <= '0;
      rd_idx_q      <= '0;
      acc_q         <= '0;
      chk_q         <= 1'b0;
      res_value_q   <= '0;
      res_kind_q    <= 1'b0;
      reply_valid_q <= 1'b0;
      reply_value_q <= '0;
      reply_kind_q  <= 1'b0;
    end else begin
      if (reply_valid_q && reply_ready_i && (state_q != ST_REPLY)) begin
        reply_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          chk_q    <= 1'b0;
          rd_idx_q <= '0;
          acc_q    <= '0;
          if (take) begin
            op_q <= cmd_i.op;
            unique case (cmd_i.op)
              OP_LOAD: begin
                if (count_q < CNT_W'(STORE_DEPTH)) begin
                  count_q <= count_q + 1'b1;
                end
              end
              OP_PICK: begin
                if (count_q == '0) begin
                  res_value_q <= '1;
                  res_kind_q  <= 1'b0;
                  state_q     <= ST_REPLY;
                end else begin
                  state_q <= ST_MOD;
                end
              end
              OP_COUNT: begin
                pivot_q <= cmd_i.operand;
                state_q <= ST_SCAN;
              end
              OP_DROP_SMALLER, OP_DROP_LARGER: begin
                state_q <= ST_SCAN;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state_q <= ST_PICK_RD;
          end
        end
        ST_PICK_RD: begin
          res_value_q <= rdata_q;
          res_kind_q  <= 1'b0;
          state_q     <= ST_REPLY;
        end
        ST_SCAN: begin
          chk_q <= issue;
          if (issue) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
          if (chk_q && hit) begin
            acc_q <= acc_q + 1'b1;
          end
          if (scan_done) begin
            if (op_q == OP_COUNT) begin
              res_value_q <= $signed({{(WORD_W - CNT_W){1'b0}}, acc_q});
              res_kind_q  <= 1'b1;
              state_q     <= ST_REPLY;
            end else begin
              count_q <= acc_q;
              state_q <= ST_IDLE;
            end
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            reply_valid_q <= 1'b1;
            reply_value_q <= res_value_q;
            reply_kind_q  <= res_kind_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign reply_valid_o = reply_valid_q;
  assign reply_value_o = reply_value_q;
  assign reply_kind_o  = reply_kind_q;
  assign stat_o.count  = count_q;
  assign stat_o.idle   = (state_q == ST_IDLE);

endmodule

// ===== hdl/pivot_partition_worker_store.sv =====
// Worker side of distributed median selection: holds up to 64 signed words and a pivot.
// A load is written straight into the store by the back end. A pick goes through the
// 16-step remainder unit and then the registered store read. A count or a drop sweeps
// each stored word once through the single read port of the store. A two-entry command
// queue separates the input side from the back end, and the reply register lets the next
// command start while a reply is still waiting. Depends on ppw_pkg, ppw_front, ppw_mod
// and ppw_back.
module pivot_partition_worker_store import ppw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [WORD_W-1:0] operand_i,
  input  logic [DRAW_W-1:0]        random_draw_i,
  output logic                     reply_valid_o,
  input  logic                     reply_ready_i,
  output logic signed [WORD_W-1:0] reply_value_o,
  output logic                     reply_kind_o
);

  logic  cmd_valid;
  logic  cmd_ready;
  cmd_t  cmd;
  stat_t stat;

  ppw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .operand_i     (operand_i),
    .random_draw_i (random_draw_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  ppw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .reply_valid_o (reply_valid_o),
    .reply_ready_i (reply_ready_i),
    .reply_value_o (reply_value_o),
    .reply_kind_o  (reply_kind_o),
    .stat_o        (stat)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.count <= CNT_W'(STORE_DEPTH))
    else $error("Element count exceeds the store depth.");

  a_count_reply_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reply_valid_o && reply_kind_o |->
      (reply_value_o >= 0) && (reply_value_o <= WORD_W'(STORE_DEPTH)))
    else $error("Count reply lies outside the possible range.");

  a_full_queue_offers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> cmd_valid && !stat.idle || cmd_valid)
    else $error("Input stalled while the command queue is empty.");
`endif

endmodule
